// ===== src/sofi_pkg.sv =====
// ----------------------------------------------------------------------------
// sofi_pkg
// Shared types and fixed field widths of the second-order autocorrelation core.
// ----------------------------------------------------------------------------
package sofi_pkg;

  localparam int PIX_W    = 16;  // pixel intensity
  localparam int PSUM_W   = 42;  // per-pixel product sum
  localparam int ISUM_W   = 26;  // per-pixel intensity sum
  localparam int SOFI_W   = 42;  // signed result, 8 fraction bits
  localparam int MEAN_W   = 24;  // unsigned Q16.8 mean
  localparam int LAG_W    = 4;   // lag register
  localparam int FPIX_W   = 13;  // frame_pixels register
  localparam int CFG_W    = 13;  // widest register
  localparam int FRAC_W   = 8;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_LAG          = 1'b0,
    REG_FRAME_PIXELS = 1'b1
  } reg_index_t;

endpackage

// ===== src/sofi_div.sv =====
// ----------------------------------------------------------------------------
// sofi_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sofi_div #(
  parameter int DW  = 62,  // dividend and quotient width
  parameter int DVW = 22   // divisor width
) (
  input  logic           clk,
  input  logic           en,
  input  logic [DW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic [DW-1:0]  quotient
);

  logic [DVW-1:0] rem_q  [DW];
  logic [DW-1:0]  work_q [DW];
  logic [DVW-1:0] dvs_q  [DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [DVW-1:0] rem_in;
    logic [DW-1:0]  work_in;
    logic [DVW-1:0] dvs_in;
    logic [DVW:0]   trial;
    logic [DVW:0]   diff;
    logic           ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = dividend;
      assign dvs_in  = divisor;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign work_in = work_q[i-1];
      assign dvs_in  = dvs_q[i-1];
    end

    always_comb begin
      trial = {rem_in, work_in[DW-1]};
      diff  = trial - {1'b0, dvs_in};
      ge    = (trial >= {1'b0, dvs_in});
    end

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
        work_q[i] <= {work_in[DW-2:0], ge};
        dvs_q[i]  <= dvs_in;
      end
    end
  end

  assign quotient = work_q[DW-1];

endmodule

// ===== src/sofi_second_order_autocorrelation_core.sv =====
// ----------------------------------------------------------------------------
// sofi_second_order_autocorrelation_core
// Lagged-frame autocorrelation with per-pixel sums held in block memory.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid, in_stall, cmd, pixel        | into core
//   out     | out_valid, out_stall, sofi_value,     | out of core
//           | mean_value, last_pixel, no_data,      |
//           | overflow                              |
//   cfg     | cfg_write, cfg_index, cfg_data        | into core
//
// One item per cycle while in_stall is low. A push writes its sums from stage 1;
// a readout passes stages 1 to 3, the bit-per-stage dividers and the output register.
// After reset the sum memory is swept to zero, address by address, with
// in_stall high. The pipeline freezes only when a readout reaches its end while
// the output register holds an item that is stalled.
// ----------------------------------------------------------------------------
module sofi_second_order_autocorrelation_core #(
  parameter int MAX_LAG    = 8,
  parameter int MAX_PIXELS = 4096,
  parameter int MAX_EVALS  = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic [sofi_pkg::PIX_W-1:0]          pixel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sofi_pkg::SOFI_W-1:0]  sofi_value,
  output logic [sofi_pkg::MEAN_W-1:0]         mean_value,
  output logic                                last_pixel,
  output logic                                no_data,
  output logic                                overflow,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [sofi_pkg::CFG_W-1:0]          cfg_data
);

  localparam int PW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int SW  = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
  localparam int HW  = $clog2(MAX_LAG + 1);
  localparam int CW  = $clog2(MAX_EVALS + 1);
  localparam int AW  = sofi_pkg::PSUM_W + CW;
  localparam int BW  = 2 * sofi_pkg::ISUM_W;
  localparam int MW  = (AW > BW) ? AW : BW;
  localparam int DW  = MW + sofi_pkg::FRAC_W + 1;
  localparam int DVW = 2 * CW;
  localparam int SUM_W = sofi_pkg::PSUM_W + sofi_pkg::ISUM_W;
  localparam int RING_DEPTH = 2 ** (SW + PW);

  typedef struct packed {
    logic valid;
    logic neg;
    logic no_data;
    logic last;
    logic ovf;
  } side_t;

  // Configuration and stream control.
  logic [sofi_pkg::LAG_W-1:0]  lag;
  logic [sofi_pkg::FPIX_W-1:0] frame_pixels;
  logic [CW-1:0] eval_count, eval_count_next;
  logic [HW-1:0] frames_held, frames_held_next;
  logic [SW-1:0] ring_slot, ring_slot_next;
  logic [PW-1:0] push_pos, push_pos_next;
  logic [PW-1:0] read_pos, read_pos_next;
  logic          overflow_flag, overflow_flag_next;

  logic          clr_busy;
  logic [PW-1:0] clr_addr;

  logic          en;
  logic          accept;
  logic          is_read;
  logic [HW-1:0] eff_lag;
  logic [31:0]   eff_pix;
  logic          held;
  logic          acc;
  logic          push_end;
  logic          read_last;
  logic [PW-1:0] s0_pos;

  // Memories.
  logic [sofi_pkg::PIX_W-1:0] ring [RING_DEPTH];
  logic [sofi_pkg::PIX_W-1:0] ring_rd;
  logic [SUM_W-1:0]           sums [MAX_PIXELS];
  logic [SUM_W-1:0]           sums_rd;

  // Stage 1: memory data back.
  logic                       s1_valid;
  logic                       s1_read;
  logic                       s1_acc;
  logic [PW-1:0]              s1_pos;
  logic [sofi_pkg::PIX_W-1:0] s1_pix;
  logic [CW-1:0]              s1_n;
  logic                       s1_last;
  logic                       s1_ovf;
  logic                       fwd_hit;
  logic [SUM_W-1:0]           fwd_data;
  logic [SUM_W-1:0]           cur_sum;
  logic [sofi_pkg::PSUM_W-1:0] cur_p;
  logic [sofi_pkg::ISUM_W-1:0] cur_i;
  logic [2*sofi_pkg::PIX_W-1:0] prod;
  logic [SUM_W-1:0]           s1_wdata;
  logic                       s1_we;

  // Stage 2: sums of a readout.
  logic                        r2_valid;
  logic [sofi_pkg::PSUM_W-1:0] r2_p;
  logic [sofi_pkg::ISUM_W-1:0] r2_s;
  logic [CW-1:0]               r2_n;
  logic                        r2_last;
  logic                        r2_ovf;

  // Stage 3: products.
  logic                        r3_valid;
  logic [AW-1:0]               r3_a;
  logic [BW-1:0]               r3_b;
  logic [DVW-1:0]              r3_d;
  logic [sofi_pkg::ISUM_W-1:0] r3_s;
  logic [CW-1:0]               r3_n;
  logic                        r3_last;
  logic                        r3_ovf;

  logic          r3_neg;
  logic [MW-1:0] r3_mag;
  logic [DW-1:0] sofi_dividend;
  logic [DW-1:0] mean_dividend;
  logic [DW-1:0] sofi_q;
  logic [DW-1:0] mean_q;
  side_t         side_in;
  side_t         side [DW];
  logic [sofi_pkg::SOFI_W-1:0] q_low;

  assign en       = !(out_valid && out_stall && side[DW-1].valid);
  assign in_stall = clr_busy || !en;
  assign accept   = in_valid && !in_stall;
  assign is_read  = (sofi_pkg::cmd_t'(cmd) == sofi_pkg::CMD_READ);

  always_comb begin
    if (lag == '0) begin
      eff_lag = HW'(1);
    end else if (32'(lag) > MAX_LAG) begin
      eff_lag = HW'(MAX_LAG);
    end else begin
      eff_lag = HW'(lag);
    end
    if (frame_pixels == '0) begin
      eff_pix = 32'd1;
    end else if (32'(frame_pixels) > MAX_PIXELS) begin
      eff_pix = 32'(MAX_PIXELS);
    end else begin
      eff_pix = 32'(frame_pixels);
    end
    held      = (frames_held >= eff_lag);
    acc       = held && (eval_count < CW'(MAX_EVALS));
    push_end  = (32'(push_pos) + 32'd1 >= eff_pix);
    read_last = (32'(read_pos) + 32'd1 >= eff_pix);
    s0_pos    = is_read ? read_pos : push_pos;
  end

  always_comb begin
    eval_count_next    = eval_count;
    frames_held_next   = frames_held;
    ring_slot_next     = ring_slot;
    push_pos_next      = push_pos;
    read_pos_next      = read_pos;
    overflow_flag_next = overflow_flag;
    if (cfg_write) begin
      frames_held_next = '0;
      ring_slot_next   = '0;
      push_pos_next    = '0;
      read_pos_next    = '0;
    end else if (accept) begin
      if (!is_read) begin
        if (held && !acc) begin
          overflow_flag_next = 1'b1;
        end
        if (push_end) begin
          if (acc) begin
            eval_count_next = eval_count + CW'(1);
          end
          if (frames_held < eff_lag) begin
            frames_held_next = frames_held + HW'(1);
          end
          if (32'(ring_slot) + 32'd1 >= 32'(eff_lag)) begin
            ring_slot_next = '0;
          end else begin
            ring_slot_next = ring_slot + SW'(1);
          end
          push_pos_next = '0;
        end else begin
          push_pos_next = push_pos + PW'(1);
        end
      end else begin
        if (read_last) begin
          eval_count_next  = '0;
          frames_held_next = '0;
          ring_slot_next   = '0;
          push_pos_next    = '0;
          read_pos_next    = '0;
        end else begin
          read_pos_next = read_pos + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lag           <= sofi_pkg::LAG_W'(1);
      frame_pixels  <= sofi_pkg::FPIX_W'(4096);
      eval_count    <= '0;
      frames_held   <= '0;
      ring_slot     <= '0;
      push_pos      <= '0;
      read_pos      <= '0;
      overflow_flag <= 1'b0;
      clr_busy      <= 1'b1;
      clr_addr      <= '0;
    end else begin
      if (cfg_write) begin
        case (sofi_pkg::reg_index_t'(cfg_index))
          sofi_pkg::REG_LAG:          lag <= cfg_data[sofi_pkg::LAG_W-1:0];
          sofi_pkg::REG_FRAME_PIXELS: frame_pixels <= cfg_data;
          default: ;
        endcase
      end
      eval_count    <= eval_count_next;
      frames_held   <= frames_held_next;
      ring_slot     <= ring_slot_next;
      push_pos      <= push_pos_next;
      read_pos      <= read_pos_next;
      overflow_flag <= overflow_flag_next;
      if (clr_busy) begin
        if (32'(clr_addr) == MAX_PIXELS - 1) begin
          clr_busy <= 1'b0;
        end else begin
          clr_addr <= clr_addr + PW'(1);
        end
      end
    end
  end

  // Frame ring: the read returns the pixel from lag frames back, before this push
  // overwrites it.
  always_ff @(posedge clk) begin
    if (en) begin
      ring_rd <= ring[{ring_slot, push_pos}];
    end
    if (accept && !is_read) begin
      ring[{ring_slot, push_pos}] <= pixel;
    end
  end

  // Sum memory: every write comes from stage 1 or the clearing sweep.
  always_ff @(posedge clk) begin
    if (en) begin
      sums_rd <= sums[s0_pos];
    end
    if (clr_busy) begin
      sums[clr_addr] <= '0;
    end else if (en && s1_we) begin
      sums[s1_pos] <= s1_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
      // A write landing in the same cycle as the next read is not seen by the
      // memory read, so its data is carried forward.
      fwd_hit  <= accept && s1_we && (s1_pos == s0_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_read  <= is_read;
      s1_acc   <= acc;
      s1_pos   <= s0_pos;
      s1_pix   <= pixel;
      s1_n     <= eval_count;
      s1_last  <= read_last;
      s1_ovf   <= overflow_flag;
      fwd_data <= s1_wdata;
    end
  end

  always_comb begin
    cur_sum = fwd_hit ? fwd_data : sums_rd;
    cur_p   = cur_sum[SUM_W-1:sofi_pkg::ISUM_W];
    cur_i   = cur_sum[sofi_pkg::ISUM_W-1:0];
    prod    = ring_rd * s1_pix;
    s1_we   = s1_valid && (s1_read || s1_acc);
    if (s1_read) begin
      s1_wdata = '0;
    end else begin
      s1_wdata = {cur_p + sofi_pkg::PSUM_W'(prod), cur_i + sofi_pkg::ISUM_W'(ring_rd)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
      r3_valid <= 1'b0;
    end else if (en) begin
      r2_valid <= s1_valid && s1_read;
      r3_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_p    <= cur_p;
      r2_s    <= cur_i;
      r2_n    <= s1_n;
      r2_last <= s1_last;
      r2_ovf  <= s1_ovf;
      r3_a    <= r2_p * r2_n;
      r3_b    <= r2_s * r2_s;
      r3_d    <= r2_n * r2_n;
      r3_s    <= r2_s;
      r3_n    <= r2_n;
      r3_last <= r2_last;
      r3_ovf  <= r2_ovf;
    end
  end

  always_comb begin
    r3_neg = (MW'(r3_b) > MW'(r3_a));
    r3_mag = r3_neg ? (MW'(r3_b) - MW'(r3_a)) : (MW'(r3_a) - MW'(r3_b));
    // Adding half the divisor rounds the quotient half away from zero.
    sofi_dividend = (DW'(r3_mag) << sofi_pkg::FRAC_W) + DW'(r3_d >> 1);
    mean_dividend = (DW'(r3_s) << sofi_pkg::FRAC_W) + DW'(r3_n >> 1);
    side_in.valid   = r3_valid;
    side_in.neg     = r3_neg;
    side_in.no_data = (r3_n == '0);
    side_in.last    = r3_last;
    side_in.ovf     = r3_ovf;
  end

  sofi_div #(.DW(DW), .DVW(DVW)) u_sofi_div (
    .clk      (clk),
    .en       (en),
    .dividend (sofi_dividend),
    .divisor  (r3_d),
    .quotient (sofi_q)
  );

  sofi_div #(.DW(DW), .DVW(DVW)) u_mean_div (
    .clk      (clk),
    .en       (en),
    .dividend (mean_dividend),
    .divisor  (DVW'(r3_n)),
    .quotient (mean_q)
  );

  for (genvar i = 0; i < DW; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side[i] <= '0;
      end else if (en) begin
        side[i] <= (i == 0) ? side_in : side[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign q_low = sofi_q[sofi_pkg::SOFI_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && side[DW-1].valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && side[DW-1].valid) begin
      if (side[DW-1].no_data) begin
        sofi_value <= '0;
        mean_value <= '0;
      end else begin
        sofi_value <= side[DW-1].neg ? -q_low : q_low;
        mean_value <= mean_q[sofi_pkg::MEAN_W-1:0];
      end
      last_pixel <= side[DW-1].last;
      no_data    <= side[DW-1].no_data;
      overflow   <= side[DW-1].ovf;
    end
  end

endmodule
